### hw/rtl/pol_pkg.sv
// Shared constants, types and codes for the positional ordered list.
package pol_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 5;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int WORD_W   = 32;
	localparam int CMD_W    = 3;
	localparam int ST_W     = 2;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t NO_VALUE = -32'sd9999;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REM_POS  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic [CMP_W-1:0] at;
		logic [CMP_W-1:0] cnt;
	} ctl_t;

endpackage

### hw/rtl/pol_cell.sv
// One list slot: holds, loads the new word, or shifts from a neighbor.
module pol_cell (
	input  logic                     clk,
	input  logic [pol_pkg::CMP_W-1:0] idx,
	input  pol_pkg::ctl_t            ctl,
	input  pol_pkg::word_t           ins_value,
	input  pol_pkg::word_t           left_data,
	input  pol_pkg::word_t           right_data,
	output pol_pkg::word_t           data
);

	pol_pkg::word_t data_q;
	logic [pol_pkg::CMP_W:0] idx_nxt;

	assign idx_nxt = {1'b0, idx} + {{pol_pkg::CMP_W{1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (idx == ctl.at) begin
				data_q <= ins_value;
			end else if (idx > ctl.at && idx <= ctl.cnt) begin
				data_q <= left_data;
			end
		end else if (ctl.rem_en) begin
			// close the gap: slots from the removed one up to the old tail-1
			if (idx >= ctl.at && idx_nxt < {1'b0, ctl.cnt}) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

endmodule

### hw/rtl/positional_ordered_list.sv
// Top level of the positional ordered list: command decode, cell chain, result register.
//
//  channel | dir | tdata fields (low bit up)                      | width
//  s_*     | in  | command[2:0], value[34:3], position[39:35]      | 40
//  m_*     | out | status[1:0], removed_value[33:2],
//          |     | entry_count[38:34], zero pad[39]                | 40
//
// Each command completes at its accept edge: all cells shift or hold in parallel
// and the result lands in the output register, so one item per
// cycle is sustained while m_tready stays high.
// Reset (arst_n low) empties the list and drops any pending result; entry
// words are not cleared, only slots below the count are ever read.
// A stalled result holds the input side until it is taken, but the next item
// is accepted in the same cycle the pending one leaves.
module positional_ordered_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // command[2:0], value[34:3], position[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[1:0], removed_value[33:2], entry_count[38:34], pad
);

	// input fields
	logic [pol_pkg::CMD_W-1:0] command;
	pol_pkg::word_t            value;
	logic [pol_pkg::POS_W-1:0] position;

	assign command  = s_tdata[2:0];
	assign value    = s_tdata[34:3];
	assign position = s_tdata[39:35];

	logic [pol_pkg::CNT_W-1:0] count_q;
	logic [pol_pkg::CMP_W-1:0] cnt_c;
	logic [pol_pkg::CMP_W-1:0] pos_c;
	logic                      accept;

	logic                      m_tvalid_q;
	logic [39:0]               m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cnt_c    = pol_pkg::CMP_W'(count_q);
	assign pos_c    = pol_pkg::CMP_W'(position);

	// decode
	logic                      is_ins;
	logic                      is_rem;
	logic [pol_pkg::CMP_W-1:0] at;
	logic [pol_pkg::ST_W-1:0]  status;
	logic                      ins_ok;
	logic                      rem_ok;

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		at     = '0;
		status = pol_pkg::ST_OK;
		case (command)
			pol_pkg::CMD_INS_HEAD: begin
				is_ins = 1'b1;
				at     = '0;
			end
			pol_pkg::CMD_INS_TAIL: begin
				is_ins = 1'b1;
				at     = cnt_c;
			end
			pol_pkg::CMD_INS_POS: begin
				is_ins = 1'b1;
				at     = pos_c;
			end
			pol_pkg::CMD_REM_HEAD: begin
				is_rem = 1'b1;
				at     = '0;
			end
			pol_pkg::CMD_REM_TAIL: begin
				is_rem = 1'b1;
				at     = cnt_c - {{(pol_pkg::CMP_W-1){1'b0}}, 1'b1};
			end
			pol_pkg::CMD_REM_POS: begin
				is_rem = 1'b1;
				at     = pos_c;
			end
			default: begin
				// unused codes: no change
			end
		endcase

		if (is_ins) begin
			if (at > cnt_c) begin
				status = pol_pkg::ST_BADPOS;
			end else if (cnt_c >= pol_pkg::CMP_W'(pol_pkg::CAPACITY)) begin
				status = pol_pkg::ST_FULL;
			end
		end else if (is_rem) begin
			// positional removal reports bad position even on an empty list
			if (command != pol_pkg::CMD_REM_POS && count_q == '0) begin
				status = pol_pkg::ST_EMPTY;
			end else if (at >= cnt_c) begin
				status = pol_pkg::ST_BADPOS;
			end
		end
	end

	assign ins_ok = accept && is_ins && status == pol_pkg::ST_OK;
	assign rem_ok = accept && is_rem && status == pol_pkg::ST_OK;

	pol_pkg::ctl_t ctl;

	assign ctl.ins_en = ins_ok;
	assign ctl.rem_en = rem_ok;
	assign ctl.at     = at;
	assign ctl.cnt    = cnt_c;

	// chain of cells
	pol_pkg::word_t cell_data [pol_pkg::CAPACITY];

	for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
		pol_pkg::word_t left_w;
		pol_pkg::word_t right_w;

		if (i == 0) begin : g_head
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == pol_pkg::CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pol_cell u_cell (
			.clk        (clk),
			.idx        (pol_pkg::CMP_W'(i)),
			.ctl        (ctl),
			.ins_value  (value),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	// removed word and next count
	pol_pkg::word_t            removed;
	logic [pol_pkg::CNT_W-1:0] count_nxt;

	always_comb begin
		removed   = pol_pkg::NO_VALUE;
		count_nxt = count_q;
		if (rem_ok) begin
			removed   = cell_data[at[pol_pkg::IDX_W-1:0]];
			count_nxt = count_q - {{(pol_pkg::CNT_W-1){1'b0}}, 1'b1};
		end else if (ins_ok) begin
			count_nxt = count_q + {{(pol_pkg::CNT_W-1){1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, 5'(count_nxt), removed, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
		else $error("count above capacity");

	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !accept) |=> !m_tvalid)
		else $error("result repeated after being taken");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> count_q == $past(count_q) + {{(pol_pkg::CNT_W-1){1'b0}}, 1'b1})
		else $error("insert did not grow the count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ins && status == pol_pkg::ST_FULL)
			|-> count_q == pol_pkg::CNT_W'(pol_pkg::CAPACITY))
		else $error("full reported below capacity");

endmodule
